[sv/sdm_pkg.sv]
// sdm_pkg: shared constants, codes, sequencer state type and weight tables
// for the surround downmix matrix. No dependencies.
package sdm_pkg;

  localparam int DEF_MAX_IN_CHANNELS = 8;
  localparam int DEF_SAMPLE_BITS     = 24;

  localparam int LAYOUT_W   = 4;
  localparam int CH_W       = 4;
  localparam int TYPES_W    = 32;
  localparam int TYPE_W     = 4;
  localparam int POS_W      = 3;
  localparam int NUM_OUT    = 6;
  localparam int WEIGHT_W   = 17;
  localparam int FRAC_W     = 16;
  localparam int ROUND_HALF = 32768;
  localparam int WS_W       = 3;
  localparam int ROW_W      = NUM_OUT * WS_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LAYOUT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_TYPES = 2'd2;

  localparam logic [LAYOUT_W-1:0] RST_OUT_LAYOUT    = 4'd0;
  localparam logic [CH_W-1:0]     RST_IN_CHANNELS   = 4'd2;
  localparam logic [TYPES_W-1:0]  RST_CHANNEL_TYPES = 32'h0000_0021;

  // output layouts
  localparam logic [LAYOUT_W-1:0] LAYOUT_PASS   = 4'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_MONO   = 4'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_STEREO = 4'd2;
  localparam logic [LAYOUT_W-1:0] LAYOUT_2F1R   = 4'd3;
  localparam logic [LAYOUT_W-1:0] LAYOUT_3F     = 4'd4;
  localparam logic [LAYOUT_W-1:0] LAYOUT_3F1R   = 4'd5;
  localparam logic [LAYOUT_W-1:0] LAYOUT_2F2R   = 4'd6;
  localparam logic [LAYOUT_W-1:0] LAYOUT_3F2R   = 4'd7;
  localparam logic [LAYOUT_W-1:0] LAYOUT_3F2R_L = 4'd8;

  // speaker types
  localparam logic [TYPE_W-1:0] TYPE_MONO = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_FL   = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_FR   = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_FC   = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_RL   = 4'd4;
  localparam logic [TYPE_W-1:0] TYPE_RR   = 4'd5;
  localparam logic [TYPE_W-1:0] TYPE_RC   = 4'd6;
  localparam logic [TYPE_W-1:0] TYPE_SL   = 4'd7;
  localparam logic [TYPE_W-1:0] TYPE_SR   = 4'd8;
  localparam logic [TYPE_W-1:0] TYPE_LFE  = 4'd9;

  // weight selector codes
  localparam logic [WS_W-1:0] WS_Z = 3'd0;  // 0
  localparam logic [WS_W-1:0] WS_U = 3'd1;  // 1.0
  localparam logic [WS_W-1:0] WS_H = 3'd2;  // 0.5
  localparam logic [WS_W-1:0] WS_T = 3'd3;  // 0.33
  localparam logic [WS_W-1:0] WS_Q = 3'd4;  // 0.25
  localparam logic [WS_W-1:0] WS_F = 3'd5;  // 0.2

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_EMIT
  } sdm_state_t;

  function automatic logic [WEIGHT_W-1:0] sel_weight(input logic [WS_W-1:0] sel);
    logic [WEIGHT_W-1:0] w;
    case (sel)
      WS_U:    w = 17'd65536;
      WS_H:    w = 17'd32768;
      WS_T:    w = 17'd21627;
      WS_Q:    w = 17'd16384;
      WS_F:    w = 17'd13107;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

  function automatic logic [POS_W-1:0] out_count(input logic [LAYOUT_W-1:0] layout);
    logic [POS_W-1:0] n;
    case (layout)
      LAYOUT_MONO:   n = 3'd1;
      LAYOUT_STEREO: n = 3'd2;
      LAYOUT_2F1R,
      LAYOUT_3F:     n = 3'd3;
      LAYOUT_3F1R,
      LAYOUT_2F2R:   n = 3'd4;
      LAYOUT_3F2R:   n = 3'd5;
      LAYOUT_3F2R_L: n = 3'd6;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  // Weight selectors of one speaker type into all outputs; output k sits in
  // bits [3k+2:3k], so the rightmost entry below is output 0.
  function automatic logic [ROW_W-1:0] mix_row(input logic [LAYOUT_W-1:0] layout,
                                               input logic [TYPE_W-1:0] typ);
    logic [ROW_W-1:0] r;
    r = '0;
    case (layout)
      LAYOUT_MONO: r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_Z, WS_U};
      LAYOUT_STEREO: begin
        case (typ)
          TYPE_MONO, TYPE_FC, TYPE_RC, TYPE_LFE: r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_H, WS_H};
          TYPE_FL, TYPE_RL, TYPE_SL:             r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_Z, WS_U};
          TYPE_FR, TYPE_RR, TYPE_SR:             r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_U, WS_Z};
          default:                               r = '0;
        endcase
      end
      LAYOUT_2F1R: begin
        case (typ)
          TYPE_MONO, TYPE_FC:        r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_H, WS_H};
          TYPE_FL:                   r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_Z, WS_U};
          TYPE_FR:                   r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_U, WS_Z};
          TYPE_RL, TYPE_RR, TYPE_RC: r = {WS_Z, WS_Z, WS_Z, WS_U, WS_Z, WS_Z};
          TYPE_SL:                   r = {WS_Z, WS_Z, WS_Z, WS_H, WS_Z, WS_H};
          TYPE_SR:                   r = {WS_Z, WS_Z, WS_Z, WS_H, WS_H, WS_Z};
          TYPE_LFE:                  r = {WS_Z, WS_Z, WS_Z, WS_T, WS_T, WS_T};
          default:                   r = '0;
        endcase
      end
      LAYOUT_3F: begin
        case (typ)
          TYPE_MONO, TYPE_FC, TYPE_RC: r = {WS_Z, WS_Z, WS_Z, WS_U, WS_Z, WS_Z};
          TYPE_FL, TYPE_RL, TYPE_SL:   r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_Z, WS_U};
          TYPE_FR, TYPE_RR, TYPE_SR:   r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_U, WS_Z};
          TYPE_LFE:                    r = {WS_Z, WS_Z, WS_Z, WS_T, WS_T, WS_T};
          default:                     r = '0;
        endcase
      end
      LAYOUT_3F1R: begin
        case (typ)
          TYPE_MONO, TYPE_FC:        r = {WS_Z, WS_Z, WS_U, WS_Z, WS_Z, WS_Z};
          TYPE_FL:                   r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_Z, WS_U};
          TYPE_FR:                   r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_U, WS_Z};
          TYPE_RL, TYPE_RR, TYPE_RC: r = {WS_Z, WS_Z, WS_Z, WS_U, WS_Z, WS_Z};
          TYPE_SL:                   r = {WS_Z, WS_Z, WS_Z, WS_H, WS_Z, WS_H};
          TYPE_SR:                   r = {WS_Z, WS_Z, WS_Z, WS_H, WS_H, WS_Z};
          TYPE_LFE:                  r = {WS_Z, WS_Z, WS_Q, WS_Q, WS_Q, WS_Q};
          default:                   r = '0;
        endcase
      end
      LAYOUT_2F2R: begin
        case (typ)
          TYPE_MONO, TYPE_FC: r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_H, WS_H};
          TYPE_FL:            r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_Z, WS_U};
          TYPE_FR:            r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_U, WS_Z};
          TYPE_RL:            r = {WS_Z, WS_Z, WS_Z, WS_U, WS_Z, WS_Z};
          TYPE_RR:            r = {WS_Z, WS_Z, WS_U, WS_Z, WS_Z, WS_Z};
          TYPE_RC:            r = {WS_Z, WS_Z, WS_H, WS_H, WS_Z, WS_Z};
          TYPE_SL:            r = {WS_Z, WS_Z, WS_Z, WS_H, WS_Z, WS_H};
          TYPE_SR:            r = {WS_Z, WS_Z, WS_H, WS_Z, WS_H, WS_Z};
          TYPE_LFE:           r = {WS_Z, WS_Z, WS_Q, WS_Q, WS_Q, WS_Q};
          default:            r = '0;
        endcase
      end
      LAYOUT_3F2R: begin
        case (typ)
          TYPE_MONO, TYPE_FC: r = {WS_Z, WS_U, WS_Z, WS_Z, WS_Z, WS_Z};
          TYPE_FL:            r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_Z, WS_U};
          TYPE_FR:            r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_U, WS_Z};
          TYPE_RL:            r = {WS_Z, WS_Z, WS_Z, WS_U, WS_Z, WS_Z};
          TYPE_RR:            r = {WS_Z, WS_Z, WS_U, WS_Z, WS_Z, WS_Z};
          TYPE_RC:            r = {WS_Z, WS_Z, WS_H, WS_H, WS_Z, WS_Z};
          TYPE_SL:            r = {WS_Z, WS_Z, WS_Z, WS_H, WS_Z, WS_H};
          TYPE_SR:            r = {WS_Z, WS_Z, WS_H, WS_Z, WS_H, WS_Z};
          TYPE_LFE:           r = {WS_Z, WS_F, WS_F, WS_F, WS_F, WS_F};
          default:            r = '0;
        endcase
      end
      LAYOUT_3F2R_L: begin
        case (typ)
          TYPE_MONO, TYPE_FC: r = {WS_Z, WS_U, WS_Z, WS_Z, WS_Z, WS_Z};
          TYPE_FL:            r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_Z, WS_U};
          TYPE_FR:            r = {WS_Z, WS_Z, WS_Z, WS_Z, WS_U, WS_Z};
          TYPE_RL:            r = {WS_Z, WS_Z, WS_Z, WS_U, WS_Z, WS_Z};
          TYPE_RR:            r = {WS_Z, WS_Z, WS_U, WS_Z, WS_Z, WS_Z};
          TYPE_RC:            r = {WS_Z, WS_Z, WS_H, WS_H, WS_Z, WS_Z};
          TYPE_SL:            r = {WS_Z, WS_Z, WS_Z, WS_H, WS_Z, WS_H};
          TYPE_SR:            r = {WS_Z, WS_Z, WS_H, WS_Z, WS_H, WS_Z};
          TYPE_LFE:           r = {WS_U, WS_Z, WS_Z, WS_Z, WS_Z, WS_Z};
          default:            r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/sdm_mul.sv]
// sdm_mul: shared weight multiplier, registered product, round to nearest.
// Depends on sdm_pkg.
module sdm_mul #(
  parameter int SAMPLE_BITS = sdm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  input  logic [sdm_pkg::WEIGHT_W-1:0]     weight,
  output logic signed [SAMPLE_BITS-1:0]    contrib
);

  localparam int P_W = SAMPLE_BITS + sdm_pkg::WEIGHT_W + 1;

  logic signed [sdm_pkg::WEIGHT_W:0] w_s;
  logic signed [P_W-1:0]             prod_nxt;
  logic signed [P_W-1:0]             prod_r;
  logic signed [P_W-1:0]             rnd;

  assign w_s      = {1'b0, weight};
  assign prod_nxt = sample * w_s;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // floor((p + 0.5) / 1.0) in Q.16; result always fits the sample width
  assign rnd     = prod_r + P_W'(sdm_pkg::ROUND_HALF);
  assign contrib = rnd[sdm_pkg::FRAC_W +: SAMPLE_BITS];

endmodule

[sv/sdm_div.sv]
// sdm_div: serial restoring divider, one quotient bit per cycle, signed
// dividend by a small unsigned divisor, truncating toward zero. Uses sdm_pkg.
module sdm_div #(
  parameter int ACC_W = 28
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [ACC_W-1:0]      dividend,
  input  logic [sdm_pkg::CH_W-1:0]     divisor,
  output logic                         done,
  output logic signed [ACC_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(ACC_W + 1);
  localparam int REM_W = sdm_pkg::CH_W - 1;

  logic [ACC_W-1:0]          mag_r;
  logic [REM_W-1:0]          rem_r;
  logic [sdm_pkg::CH_W-1:0]  den_r;
  logic                      neg_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      done_r;
  logic [sdm_pkg::CH_W-1:0]  trial;
  logic [sdm_pkg::CH_W-1:0]  diff;
  logic                      ge;
  logic [ACC_W-1:0]          abs_in;

  assign abs_in = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
  assign trial  = {rem_r, mag_r[ACC_W-1]};
  assign ge     = (trial >= den_r);
  assign diff   = trial - den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(ACC_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= abs_in;
      rem_r <= '0;
      den_r <= divisor;
      neg_r <= dividend[ACC_W-1];
    end else if (cnt_r != '0) begin
      mag_r <= {mag_r[ACC_W-2:0], ge};
      rem_r <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -signed'(mag_r) : signed'(mag_r);

endmodule

[sv/surround_downmix_matrix.sv]
// surround_downmix_matrix: top level of the channel downmix matrix.
// Depends on sdm_pkg, sdm_mul (weight multiplier) and sdm_div (mono divider).
//
// Input channel: in_valid / in_stall / in_sample, one channel sample per
// request, channels interleaved in order. in_stall is high while an item is
// being worked on; the block takes one item at a time.
// Output channel: out_valid / out_stall with out_sample, out_index, out_last.
// Results sit in an output register, so a new input item is taken while a
// finished result still waits for the receiver.
// Config: cfg_we / cfg_index / cfg_wdata; the user must write them only
// while idle, and the block itself does not enforce this. Steps per input item:
//   pass-through layouts: accept, then load the output register.
//   mixing layouts: accept, then multiply and accumulate in the shared
//   multiplier for each output of the layout; a frame's last channel then
//   moves the results out one at a time through the output register.
//   mono: the last channel also runs the serial divider, then emits it.
// A stalled receiver holds the current result; the sequencer waits.
// Reset (synchronous, rst_n low) clears accumulators, channel position and
// config to its defaults: pass-through, two channels, types FL and FR.
module surround_downmix_matrix #(
  parameter int MAX_IN_CHANNELS = sdm_pkg::DEF_MAX_IN_CHANNELS,
  parameter int SAMPLE_BITS     = sdm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config
  input  logic                              cfg_we,
  input  logic [sdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  // result requests
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_sample,
  output logic [sdm_pkg::POS_W-1:0]         out_index,
  output logic                              out_last
);

  // 28 bits at defaults: enough for a full frame of unity-weight samples
  localparam int ACC_W = SAMPLE_BITS + $clog2(MAX_IN_CHANNELS) + 1;
  localparam logic [sdm_pkg::CH_W-1:0] MAX_CH = sdm_pkg::CH_W'(MAX_IN_CHANNELS);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  // config registers
  logic [sdm_pkg::LAYOUT_W-1:0] layout_r;
  logic [sdm_pkg::CH_W-1:0]     chans_r;
  logic [sdm_pkg::TYPES_W-1:0]  types_r;

  // sequencer and item state
  sdm_pkg::sdm_state_t          state_r, state_nxt;
  logic [sdm_pkg::POS_W-1:0]    k_r;
  logic [sdm_pkg::POS_W-1:0]    pos_r;
  logic [sdm_pkg::POS_W-1:0]    item_pos_r;
  logic                         end_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [ACC_W-1:0]      acc_r [sdm_pkg::NUM_OUT];

  // output register
  logic                         out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [sdm_pkg::POS_W-1:0]    out_index_r;
  logic                         out_last_r;

  // control
  logic                         accept;
  logic                         mul_en;
  logic                         acc_en;
  logic                         div_start;
  logic                         div_done;
  logic                         emit_load;
  logic                         out_free;

  // datapath
  logic [sdm_pkg::CH_W-1:0]     chans_eff;
  logic                         end_now;
  logic [sdm_pkg::CH_W-1:0]     den;
  logic                         is_pass;
  logic                         is_mono;
  logic [sdm_pkg::POS_W-1:0]    n_out;
  logic [sdm_pkg::POS_W-1:0]    last_k;
  logic                         emit_final;
  logic [sdm_pkg::TYPE_W-1:0]   typ;
  logic [sdm_pkg::ROW_W-1:0]    row;
  logic [sdm_pkg::WS_W-1:0]     wsel;
  logic [sdm_pkg::WEIGHT_W-1:0] weight;
  logic signed [SAMPLE_BITS-1:0] contrib;
  logic signed [ACC_W-1:0]      acc_sel;
  logic signed [ACC_W-1:0]      acc_sum;
  logic signed [ACC_W-1:0]      div_q;
  logic signed [ACC_W-1:0]      sat_src;
  logic signed [SAMPLE_BITS-1:0] sat_val;
  logic signed [SAMPLE_BITS-1:0] emit_sample;
  logic [sdm_pkg::POS_W-1:0]    emit_index;
  logic                         emit_last;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= sdm_pkg::RST_OUT_LAYOUT;
      chans_r  <= sdm_pkg::RST_IN_CHANNELS;
      types_r  <= sdm_pkg::RST_CHANNEL_TYPES;
    end else if (cfg_we) begin
      case (cfg_index)
        sdm_pkg::REG_OUT_LAYOUT:    layout_r <= cfg_wdata[sdm_pkg::LAYOUT_W-1:0];
        sdm_pkg::REG_IN_CHANNELS:   chans_r  <= cfg_wdata[sdm_pkg::CH_W-1:0];
        sdm_pkg::REG_CHANNEL_TYPES: types_r  <= cfg_wdata[sdm_pkg::TYPES_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- frame decoding
  // channel count 0 acts as 1, anything above the maximum as the maximum
  always_comb begin
    if (chans_r == '0) begin
      chans_eff = sdm_pkg::CH_W'(1);
    end else if (chans_r > MAX_CH) begin
      chans_eff = MAX_CH;
    end else begin
      chans_eff = chans_r;
    end
  end

  // a lowered channel count mid-frame ends the frame at once
  assign end_now = ({1'b0, pos_r} + sdm_pkg::CH_W'(1)) >= chans_eff;
  // mono divisor: channels rounded up to even
  assign den     = (chans_eff + sdm_pkg::CH_W'(1)) & ~sdm_pkg::CH_W'(1);

  // undefined layout codes pass through like layout 0
  assign is_pass = !(layout_r inside {[sdm_pkg::LAYOUT_MONO : sdm_pkg::LAYOUT_3F2R_L]});
  assign is_mono = (layout_r == sdm_pkg::LAYOUT_MONO);
  assign n_out   = sdm_pkg::out_count(layout_r);
  assign last_k  = is_pass ? '0 : n_out - 1'b1;

  // speaker type of the current channel and its weight into output k
  assign typ    = types_r[{item_pos_r, 2'b00} +: sdm_pkg::TYPE_W];
  assign row    = sdm_pkg::mix_row(layout_r, typ);
  assign wsel   = row[5'(k_r) * 5'd3 +: sdm_pkg::WS_W];
  assign weight = sdm_pkg::sel_weight(wsel);

  // --------------------------------------------------------- shared units
  sdm_mul #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mul (
    .clk     (clk),
    .en      (mul_en),
    .sample  (sample_r),
    .weight  (weight),
    .contrib (contrib)
  );

  assign acc_sel = acc_r[k_r];
  assign acc_sum = acc_sel + {{(ACC_W - SAMPLE_BITS){contrib[SAMPLE_BITS-1]}}, contrib};

  // mono divide starts from the final sum, before it lands in acc_r
  sdm_div #(
    .ACC_W (ACC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_sum),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  // ----------------------------------------------------------- saturation
  assign sat_src = is_mono ? div_q : acc_sel;

  always_comb begin
    if (sat_src > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (sat_src < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = sat_src[SAMPLE_BITS-1:0];
    end
  end

  assign emit_final  = (k_r == last_k);
  assign emit_sample = is_pass ? sample_r : sat_val;
  assign emit_index  = is_pass ? item_pos_r : k_r;
  assign emit_last   = is_pass ? end_r : emit_final;

  assign out_free = !out_valid_r || !out_stall;

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = is_pass ? sdm_pkg::ST_EMIT : sdm_pkg::ST_MUL;
        end
      end
      sdm_pkg::ST_MUL: state_nxt = sdm_pkg::ST_ACC;
      sdm_pkg::ST_ACC: begin
        if (k_r != last_k) begin
          state_nxt = sdm_pkg::ST_MUL;
        end else if (!end_r) begin
          state_nxt = sdm_pkg::ST_IDLE;
        end else if (is_mono) begin
          state_nxt = sdm_pkg::ST_DIV;
        end else begin
          state_nxt = sdm_pkg::ST_EMIT;
        end
      end
      sdm_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = sdm_pkg::ST_EMIT;
        end
      end
      sdm_pkg::ST_EMIT: begin
        if (out_free && emit_final) begin
          state_nxt = sdm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sdm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != sdm_pkg::ST_IDLE);
    mul_en    = (state_r == sdm_pkg::ST_MUL);
    acc_en    = (state_r == sdm_pkg::ST_ACC);
    div_start = (state_r == sdm_pkg::ST_ACC) && emit_final && end_r && is_mono;
    emit_load = (state_r == sdm_pkg::ST_EMIT) && out_free;
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdm_pkg::ST_IDLE;
      k_r     <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        k_r   <= '0;
        pos_r <= end_now ? '0 : pos_r + 1'b1;
      end else if (acc_en || emit_load) begin
        k_r   <= emit_final ? '0 : k_r + 1'b1;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r   <= in_sample;
      item_pos_r <= pos_r;
      end_r      <= end_now;
    end
  end

  // accumulators: cleared when the frame's last result leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sdm_pkg::NUM_OUT; i++) begin
        acc_r[i] <= '0;
      end
    end else if (acc_en) begin
      acc_r[k_r] <= acc_sum;
    end else if (emit_load && emit_final && end_r) begin
      for (int i = 0; i < sdm_pkg::NUM_OUT; i++) begin
        acc_r[i] <= '0;
      end
    end
  end

  // --------------------------------------------------------- output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_sample_r <= emit_sample;
      out_index_r  <= emit_index;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_index  = out_index_r;
  assign out_last   = out_last_r;

endmodule

[sv/sdm_chk.sv]
// sdm_chk: port-level assertions for surround_downmix_matrix, bound below.
// Depends on sdm_pkg.
module sdm_chk #(
  parameter int SAMPLE_BITS = sdm_pkg::DEF_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample,
  input logic [sdm_pkg::POS_W-1:0]     out_index,
  input logic                          out_last
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // one item at a time: an accepted item blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an accept");

  // a pending result carries fully defined fields
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_sample, out_index, out_last}))
    else $error("pending result has unknown fields");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_sample) && $stable(out_index) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind surround_downmix_matrix sdm_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_sdm_chk (.*);
